// ===== rtl/dlsi_pkg.sv =====
`timescale 1ns / 1ps
package dlsi_pkg;

  localparam int DEF_TOTAL_LINES   = 263;
  localparam int DEF_VISIBLE_LINES = 192;

  localparam int STATUS_W = 16;
  localparam int LINE_W   = 9;
  localparam int NUM_CPU  = 2;

  localparam logic [STATUS_W-1:0] WRITABLE_MASK = 16'hFFB8;

  localparam int BIT_VBLANK    = 0;
  localparam int BIT_HBLANK    = 1;
  localparam int BIT_MATCH     = 2;
  localparam int BIT_EN_VBLANK = 3;
  localparam int BIT_EN_HBLANK = 4;
  localparam int BIT_EN_MATCH  = 5;

  typedef enum logic [1:0] {
    OP_HBLANK = 2'd0,
    OP_EOL    = 2'd1,
    OP_WRITE  = 2'd2
  } op_t;

  typedef logic [STATUS_W-1:0] status_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic                cpu_select;
    logic [STATUS_W-1:0] write_mask;
    logic [STATUS_W-1:0] write_value;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status_cpu0;
    logic [STATUS_W-1:0] status_cpu1;
    logic [LINE_W-1:0]   line_number;
    logic [NUM_CPU-1:0]  hblank_irq;
    logic [NUM_CPU-1:0]  match_irq;
    logic [NUM_CPU-1:0]  vblank_irq;
    logic                vblank_dma;
    logic                frame_ready;
  } result_t;

  // match value: bit 8 from bit 7, bits 7..0 from the high byte
  function automatic logic [LINE_W-1:0] match_value(input status_t s);
    return {s[7], s[15:8]};
  endfunction

endpackage

// ===== rtl/dlsi_in_if.sv =====
`timescale 1ns / 1ps
interface dlsi_in_if import dlsi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic                cpu_select;
  logic [STATUS_W-1:0] write_mask;
  logic [STATUS_W-1:0] write_value;

  modport source (output valid, output operation, output cpu_select,
                  output write_mask, output write_value, input ready);
  modport sink   (input valid, input operation, input cpu_select,
                  input write_mask, input write_value, output ready);
endinterface

// ===== rtl/dlsi_out_if.sv =====
`timescale 1ns / 1ps
interface dlsi_out_if import dlsi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status_cpu0;
  logic [STATUS_W-1:0] status_cpu1;
  logic [LINE_W-1:0]   line_number;
  logic [NUM_CPU-1:0]  hblank_irq;
  logic [NUM_CPU-1:0]  match_irq;
  logic [NUM_CPU-1:0]  vblank_irq;
  logic                vblank_dma;
  logic                frame_ready;

  modport source (output valid, output status_cpu0, output status_cpu1,
                  output line_number, output hblank_irq, output match_irq,
                  output vblank_irq, output vblank_dma, output frame_ready,
                  input ready);
  modport sink   (input valid, input status_cpu0, input status_cpu1,
                  input line_number, input hblank_irq, input match_irq,
                  input vblank_irq, input vblank_dma, input frame_ready,
                  output ready);
endinterface

// ===== rtl/dlsi_core.sv =====
`timescale 1ns / 1ps
module dlsi_core import dlsi_pkg::*; #(
  parameter int TOTAL_LINES   = DEF_TOTAL_LINES,
  parameter int VISIBLE_LINES = DEF_VISIBLE_LINES
) (
  input  item_t                  item,
  input  status_t [NUM_CPU-1:0]  status,
  input  logic [LINE_W-1:0]      line_count,
  output status_t [NUM_CPU-1:0]  status_next,
  output logic [LINE_W-1:0]      line_next,
  output result_t                res
);

  localparam logic [LINE_W-1:0] VIS_LINE   = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0] LAST_LINE  = LINE_W'(TOTAL_LINES - 1);
  localparam logic [LINE_W-1:0] TOTAL_LINE = LINE_W'(TOTAL_LINES);

  logic [LINE_W-1:0]   line_inc;
  logic [STATUS_W-1:0] wmask;
  logic [NUM_CPU-1:0]  hit;
  logic [NUM_CPU-1:0]  hirq;
  logic [NUM_CPU-1:0]  mirq;
  logic [NUM_CPU-1:0]  virq;
  logic                dma;

  assign line_inc = line_count + LINE_W'(1);
  assign wmask    = item.write_mask & WRITABLE_MASK;

  always_comb begin
    for (int i = 0; i < NUM_CPU; i++) begin
      hit[i] = (line_count == match_value(status[i]));
    end
  end

  always_comb begin
    status_next = status;
    line_next   = line_count;
    hirq        = '0;
    mirq        = '0;
    virq        = '0;
    dma         = 1'b0;
    case (item.operation)
      OP_HBLANK: begin
        for (int i = 0; i < NUM_CPU; i++) begin
          status_next[i][BIT_HBLANK] = 1'b1;
          hirq[i] = status[i][BIT_EN_HBLANK];
        end
      end
      OP_EOL: begin
        for (int i = 0; i < NUM_CPU; i++) begin
          status_next[i][BIT_MATCH]  = hit[i];
          status_next[i][BIT_HBLANK] = 1'b0;
          mirq[i] = hit[i] & status[i][BIT_EN_MATCH];
          if (line_inc == VIS_LINE) begin
            status_next[i][BIT_VBLANK] = 1'b1;
            virq[i] = status[i][BIT_EN_VBLANK];
          end else if (line_inc == LAST_LINE) begin
            status_next[i][BIT_VBLANK] = 1'b0;
          end
        end
        if (line_inc == VIS_LINE) begin
          dma       = 1'b1;
          line_next = line_inc;
        end else if (line_inc == LAST_LINE) begin
          line_next = line_inc;
        end else if (line_inc == TOTAL_LINE) begin
          line_next = '0;
        end else begin
          line_next = line_inc;
        end
      end
      OP_WRITE: begin
        status_next[item.cpu_select] = (status[item.cpu_select] & ~wmask)
                                     | (item.write_value & wmask);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.status_cpu0 = status_next[0];
    res.status_cpu1 = status_next[1];
    res.line_number = line_next;
    res.hblank_irq  = hirq;
    res.match_irq   = mirq;
    res.vblank_irq  = virq;
    res.vblank_dma  = dma;
    res.frame_ready = dma;
  end

endmodule

// ===== rtl/display_line_status_irq.sv =====
`timescale 1ns / 1ps
// Display line timing and status for two processors. One item is taken per
// clock cycle while the result is not stalled; each item is held in the input
// register and then moves into the result register, from which its result is
// presented for transfer.
// Status registers and the line counter update when an item moves from the
// input register into the result register, so back-to-back items see each
// other's effects in order. A stalled result holds the result register and
// then the input register; input is taken again as soon as either frees up.
module display_line_status_irq import dlsi_pkg::*; #(
  parameter int TOTAL_LINES   = DEF_TOTAL_LINES,
  parameter int VISIBLE_LINES = DEF_VISIBLE_LINES
) (
  input  logic       clk,
  input  logic       rst,
  dlsi_in_if.sink    item,
  dlsi_out_if.source result
);

  logic                   stage_valid;
  item_t                  stage_item;
  status_t [NUM_CPU-1:0]  status;
  status_t [NUM_CPU-1:0]  status_next;
  logic [LINE_W-1:0]      line_count;
  logic [LINE_W-1:0]      line_next;
  logic                   out_valid;
  result_t                out_data;
  result_t                res;
  logic                   advance;
  logic                   take;

  assign advance    = stage_valid && (!out_valid || result.ready);
  assign item.ready = !stage_valid || advance;
  assign take       = item.valid && item.ready;

  dlsi_core #(
    .TOTAL_LINES   (TOTAL_LINES),
    .VISIBLE_LINES (VISIBLE_LINES)
  ) u_core (
    .item        (stage_item),
    .status      (status),
    .line_count  (line_count),
    .status_next (status_next),
    .line_next   (line_next),
    .res         (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_item.operation   <= item.operation;
      stage_item.cpu_select  <= item.cpu_select;
      stage_item.write_mask  <= item.write_mask;
      stage_item.write_value <= item.write_value;
    end
  end

  // state
  always_ff @(posedge clk) begin
    if (rst) begin
      status     <= '0;
      line_count <= '0;
    end else if (advance) begin
      status     <= status_next;
      line_count <= line_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  assign result.valid       = out_valid;
  assign result.status_cpu0 = out_data.status_cpu0;
  assign result.status_cpu1 = out_data.status_cpu1;
  assign result.line_number = out_data.line_number;
  assign result.hblank_irq  = out_data.hblank_irq;
  assign result.match_irq   = out_data.match_irq;
  assign result.vblank_irq  = out_data.vblank_irq;
  assign result.vblank_dma  = out_data.vblank_dma;
  assign result.frame_ready = out_data.frame_ready;

endmodule

// ===== rtl/dlsi_checker.sv =====
`timescale 1ns / 1ps
module dlsi_checker import dlsi_pkg::*; #(
  parameter int TOTAL_LINES   = DEF_TOTAL_LINES,
  parameter int VISIBLE_LINES = DEF_VISIBLE_LINES
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status_cpu0,
  input logic [STATUS_W-1:0] status_cpu1,
  input logic [LINE_W-1:0]   line_number,
  input logic [NUM_CPU-1:0]  hblank_irq,
  input logic                vblank_dma,
  input logic                frame_ready
);

  localparam logic [LINE_W-1:0] VIS_LINE = LINE_W'(VISIBLE_LINES);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status_cpu0)
      && $stable(status_cpu1) && $stable(line_number))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ready |-> vblank_dma && line_number == VIS_LINE
      && status_cpu0[BIT_VBLANK] && status_cpu1[BIT_VBLANK])
    else $error("frame ready without vblank start");

  a_hirq: assert property (@(posedge clk) disable iff (rst)
    out_valid && hblank_irq[0] |-> status_cpu0[BIT_HBLANK]
      && status_cpu0[BIT_EN_HBLANK])
    else $error("hblank irq without flag and enable");

  a_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && (VISIBLE_LINES != TOTAL_LINES)
      |-> line_number < LINE_W'(TOTAL_LINES))
    else $error("line counter past last line");

endmodule

bind display_line_status_irq dlsi_checker #(
  .TOTAL_LINES   (TOTAL_LINES),
  .VISIBLE_LINES (VISIBLE_LINES)
) u_dlsi_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .status_cpu0 (result.status_cpu0),
  .status_cpu1 (result.status_cpu1),
  .line_number (result.line_number),
  .hblank_irq  (result.hblank_irq),
  .vblank_dma  (result.vblank_dma),
  .frame_ready (result.frame_ready)
);
